[rtl/multi_voice_sample_mixer_defines.svh]
// assertion macros for the voice mixer
`ifndef MULTI_VOICE_SAMPLE_MIXER_DEFINES_SVH
`define MULTI_VOICE_SAMPLE_MIXER_DEFINES_SVH

// implication checked every clock outside reset
`define MVSM_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication checked outside reset
`define MVSM_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/mvsm_pkg.sv]
// ----------------------------------------------------------------------------
// mvsm_pkg
// Shared types and constants for the multi-voice sample mixer.
// ----------------------------------------------------------------------------
package mvsm_pkg;

   localparam int VOICES_DEF       = 64;
   localparam int SAMPLE_DEPTH_DEF = 65536;
   localparam int FRAC_BITS_DEF    = 13;

   localparam logic [15:0] GAIN_UNIT   = 16'd8192;
   localparam logic [15:0] VOLUME_INIT = 16'd4096;

   typedef enum logic [2:0] {
      CMD_TICK   = 3'd0,
      CMD_WRITE  = 3'd1,
      CMD_START  = 3'd2,
      CMD_VOLUME = 3'd3,
      CMD_PAN    = 3'd4,
      CMD_SPEED  = 3'd5,
      CMD_PAUSE  = 3'd6,
      CMD_STOP   = 3'd7
   } cmd_type;

   typedef struct packed {
      logic [2:0]         command;
      logic [5:0]         voice;
      logic [15:0]        address;
      logic [16:0]        frame_count;
      logic               loop_enable;
      logic signed [15:0] write_left;
      logic signed [15:0] write_right;
      logic [15:0]        gain_a;
      logic [15:0]        gain_b;
      logic               pause_flag;
   } req_word_type;

   typedef struct packed {
      logic signed [15:0] mix_left;
      logic signed [15:0] mix_right;
      logic               frame_valid;
      logic [6:0]         started_voice;
   } rsp_word_type;

   // controller to datapath commands
   typedef struct packed {
      logic load;       // capture request word, clear accumulators
      logic scan_clr;   // reset voice scan index
      logic scan_step;  // process voice at index: read stage
      logic apply;      // apply single-voice command
      logic finish;     // build response word
   } ctl_cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic scan_last;  // scan index at last voice
      logic pipe_busy;  // mixing pipeline still holds work
   } ctl_sts_type;

endpackage

[rtl/mvsm_ctrl.sv]
// ----------------------------------------------------------------------------
// mvsm_ctrl
// Sequencer: accepts a request word, runs the voice scan on a tick or a
// start, then hands the response word to the output register.
// ----------------------------------------------------------------------------
module mvsm_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [2:0]            req_command,
   input  logic                  rsp_busy,
   output mvsm_pkg::ctl_cmd_type cmd,
   input  mvsm_pkg::ctl_sts_type sts
);
   import mvsm_pkg::*;
`include "multi_voice_sample_mixer_defines.svh"

   typedef enum logic [2:0] {S_IDLE, S_SCAN, S_DRAIN, S_APPLY, S_DONE} state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load     = 1'b1;
               cmd.scan_clr = 1'b1;
               if (req_command == CMD_TICK || req_command == CMD_START) begin
                  state_in = S_SCAN;
               end else begin
                  state_in = S_APPLY;
               end
            end
         end
         S_SCAN: begin
            cmd.scan_step = 1'b1;
            if (sts.scan_last) begin
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            if (!sts.pipe_busy) begin
               state_in = S_APPLY;
            end
         end
         S_APPLY: begin
            cmd.apply = 1'b1;
            state_in  = S_DONE;
         end
         S_DONE: begin
            if (!rsp_busy) begin
               cmd.finish = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign req_stall = (state_ff != S_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   `MVSM_ASSERT_NEXT(a_load_leaves_idle, cmd.load, state_ff != S_IDLE, "load did not start work")
   `MVSM_ASSERT_IMP(a_finish_once, cmd.finish, !cmd.scan_step && !cmd.apply, "finish overlaps work")
   `MVSM_ASSERT_NEXT(a_apply_then_done, cmd.apply, state_ff == S_DONE, "apply not followed by done")
endmodule

[rtl/mvsm_datapath.sv]
// ----------------------------------------------------------------------------
// mvsm_datapath
// Voice state, sample memory and a pipelined mixing unit that visits one
// voice per cycle during a tick scan.
// ----------------------------------------------------------------------------
module mvsm_datapath #(
   parameter int SAMPLE_DEPTH = mvsm_pkg::SAMPLE_DEPTH_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  mvsm_pkg::req_word_type req_word,
   input  mvsm_pkg::ctl_cmd_type cmd,
   output mvsm_pkg::ctl_sts_type sts,
   output mvsm_pkg::rsp_word_type rsp_word
);
   import mvsm_pkg::*;
`include "multi_voice_sample_mixer_defines.svh"

   localparam int VOICES    = VOICES_DEF;
   localparam int FRAC_BITS = FRAC_BITS_DEF;
   localparam int VW  = (VOICES > 1) ? $clog2(VOICES) : 1;
   localparam int AW  = $clog2(SAMPLE_DEPTH);
   localparam int PW  = 17 + FRAC_BITS;
   localparam int SW  = 7;   // started_voice width
   localparam int ACW = 32;  // accumulator: 64 voices of under 2^21 each

   // ------------------------------------------------------------- storage
   logic [31:0]     smem [SAMPLE_DEPTH];
   logic [15:0]     v_start  [VOICES];
   logic [16:0]     v_len    [VOICES];
   logic [PW-1:0]   v_pos    [VOICES];
   logic [15:0]     v_vol    [VOICES];
   logic [15:0]     v_lp     [VOICES];
   logic [15:0]     v_rp     [VOICES];
   logic [15:0]     v_spd    [VOICES];
   logic [VOICES-1:0] act_ff, loop_ff, pause_ff, stop_ff, gset_ff;

   req_word_type    req_ff;
   logic [VW:0]     idx_ff;
   logic signed [ACW-1:0] accl_ff, accr_ff;
   rsp_word_type    rsp_ff;
   logic [SW-1:0]   found_ff;
   logic            found_ok_ff;

   // effective gains: a voice never set since reset reads defaults
   function automatic logic [15:0] gsel(input logic set, input logic [15:0] v,
                                        input logic [15:0] d);
      return set ? v : d;
   endfunction

   logic [VW-1:0] vi, gv, va;
   assign vi = idx_ff[VW-1:0];
   assign gv = req_ff.voice[VW-1:0];
   // voice tables are read into registers: scan index, the addressed voice at load, else the held voice
   assign va = cmd.scan_step ? vi : (cmd.load ? req_word.voice[VW-1:0] : gv);

   // registered voice table read
   logic [15:0]     rv_start_ff;
   logic [16:0]     rv_len_ff;
   logic [PW-1:0]   rv_pos_ff;
   logic [15:0]     rv_vol_ff, rv_lp_ff, rv_rp_ff, rv_spd_ff;
   logic            s0_ff;
   logic [VW-1:0]   s0_vi_ff;

   always_ff @(posedge clock) begin
      rv_start_ff <= v_start[va];
      rv_len_ff   <= v_len[va];
      rv_pos_ff   <= v_pos[va];
      rv_vol_ff   <= v_vol[va];
      rv_lp_ff    <= v_lp[va];
      rv_rp_ff    <= v_rp[va];
      rv_spd_ff   <= v_spd[va];
      s0_vi_ff    <= vi;
   end

   // ------------------------------------------------------ stage 0: visit
   logic [VW-1:0] wi;
   logic [16:0]   frame0;
   logic [PW:0]   lenpos;
   logic [PW-1:0] pos_w;
   logic          hit, endhit, wrap;
   logic [15:0]   lp0, rp0, vol0, spd0;

   assign wi = s0_vi_ff;

   always_comb begin
      lp0    = gsel(gset_ff[wi], rv_lp_ff, GAIN_UNIT);
      rp0    = gsel(gset_ff[wi], rv_rp_ff, GAIN_UNIT);
      vol0   = gsel(gset_ff[wi], rv_vol_ff, VOLUME_INIT);
      spd0   = gsel(gset_ff[wi], rv_spd_ff, GAIN_UNIT);
      lenpos = {1'b0, rv_len_ff, {FRAC_BITS{1'b0}}};
      frame0 = rv_pos_ff[PW-1:FRAC_BITS];
      endhit = (frame0 >= rv_len_ff);
      wrap   = endhit && loop_ff[wi] && (rv_len_ff != 17'd0);
      // one subtract wraps a position that overran by less than one length
      pos_w  = wrap ? PW'({1'b0, rv_pos_ff} - lenpos) : rv_pos_ff;
      hit    = act_ff[wi] && !stop_ff[wi] && !pause_ff[wi] && (!endhit || wrap);
   end

   logic          p1_ff;
   logic [15:0]   p1_lp_ff, p1_rp_ff, p1_vol_ff;
   logic          p2_ff;
   logic signed [15:0] s2l_ff, s2r_ff;
   logic [15:0]   p2_lp_ff, p2_rp_ff, p2_vol_ff;
   logic          p3_ff;
   logic signed [32:0] m3l_ff, m3r_ff;
   logic [15:0]   p3_vol_ff;
   logic          p4_ff;
   logic signed [36:0] m4l_ff, m4r_ff;
   logic [16:0]   fsum;
   logic [AW-1:0] raddr;

   assign fsum  = {1'b0, rv_start_ff} + (frame0 - (wrap ? rv_len_ff : 17'd0));
   assign raddr = AW'(fsum);

   // ---------------------------------------------------- voice state update
   always_ff @(posedge clock) begin
      if (reset) begin
         act_ff   <= '0;
         loop_ff  <= '0;
         pause_ff <= '0;
         stop_ff  <= '0;
         gset_ff  <= '0;
      end else begin
         if (s0_ff && act_ff[wi]) begin
            if (stop_ff[wi]) begin
               act_ff[wi]  <= 1'b0;
               stop_ff[wi] <= 1'b0;
            end else if (!pause_ff[wi] && endhit && !wrap) begin
               stop_ff[wi] <= 1'b1;
            end
         end
         if (cmd.apply) begin
            priority case (cmd_type'(req_ff.command))
               CMD_START: begin
                  if (found_ok_ff) begin
                     act_ff[found_ff[VW-1:0]]   <= 1'b1;
                     loop_ff[found_ff[VW-1:0]]  <= req_ff.loop_enable;
                     pause_ff[found_ff[VW-1:0]] <= 1'b0;
                     stop_ff[found_ff[VW-1:0]]  <= 1'b0;
                     gset_ff[found_ff[VW-1:0]]  <= 1'b1;
                  end
               end
               CMD_VOLUME, CMD_PAN, CMD_SPEED: begin
                  if (32'(req_ff.voice) < VOICES && !gset_ff[req_ff.voice[VW-1:0]]) begin
                     gset_ff[req_ff.voice[VW-1:0]] <= 1'b1;
                  end
               end
               CMD_PAUSE: begin
                  if (32'(req_ff.voice) < VOICES) begin
                     pause_ff[req_ff.voice[VW-1:0]] <= req_ff.pause_flag;
                  end
               end
               CMD_STOP: begin
                  if (32'(req_ff.voice) < VOICES) begin
                     stop_ff[req_ff.voice[VW-1:0]] <= 1'b1;
                  end
               end
               default: ;
            endcase
         end
      end
   end

   // voice payload registers (no reset; defaults come from gset_ff)
   always_ff @(posedge clock) begin
      if (s0_ff && hit) begin
         v_pos[wi] <= pos_w + PW'(spd0);
      end
      if (cmd.apply) begin
         priority case (cmd_type'(req_ff.command))
            CMD_START: begin
               if (found_ok_ff) begin
                  v_start[found_ff[VW-1:0]] <= req_ff.address;
                  v_len[found_ff[VW-1:0]]   <= req_ff.frame_count;
                  v_pos[found_ff[VW-1:0]]   <= '0;
                  v_vol[found_ff[VW-1:0]]   <= VOLUME_INIT;
                  v_lp[found_ff[VW-1:0]]    <= GAIN_UNIT;
                  v_rp[found_ff[VW-1:0]]    <= GAIN_UNIT;
                  v_spd[found_ff[VW-1:0]]   <= GAIN_UNIT;
               end
            end
            CMD_VOLUME, CMD_PAN, CMD_SPEED: begin
               if (32'(req_ff.voice) < VOICES) begin
                  // fill untouched gains with defaults on first set
                  v_vol[gv] <= (cmd_type'(req_ff.command) == CMD_VOLUME) ? req_ff.gain_a
                               : gsel(gset_ff[gv], rv_vol_ff, VOLUME_INIT);
                  v_lp[gv]  <= (cmd_type'(req_ff.command) == CMD_PAN) ? req_ff.gain_a
                               : gsel(gset_ff[gv], rv_lp_ff, GAIN_UNIT);
                  v_rp[gv]  <= (cmd_type'(req_ff.command) == CMD_PAN) ? req_ff.gain_b
                               : gsel(gset_ff[gv], rv_rp_ff, GAIN_UNIT);
                  v_spd[gv] <= (cmd_type'(req_ff.command) == CMD_SPEED) ? req_ff.gain_a
                               : gsel(gset_ff[gv], rv_spd_ff, GAIN_UNIT);
               end
            end
            default: ;
         endcase
      end
   end

   // sample memory: one write port, one registered read port
   logic [31:0] rd_ff;
   always_ff @(posedge clock) begin
      if (cmd.load && req_word.command == CMD_WRITE) begin
         smem[AW'(req_word.address)] <= {req_word.write_right, req_word.write_left};
      end
      rd_ff <= smem[raddr];
   end

   // ------------------------------------------------------- mixing pipeline
   always_ff @(posedge clock) begin
      if (reset) begin
         s0_ff <= 1'b0;
         p1_ff <= 1'b0;
         p2_ff <= 1'b0;
         p3_ff <= 1'b0;
         p4_ff <= 1'b0;
      end else begin
         s0_ff <= cmd.scan_step && req_ff.command == CMD_TICK;
         p1_ff <= s0_ff && hit;
         p2_ff <= p1_ff;
         p3_ff <= p2_ff;
         p4_ff <= p3_ff;
      end
   end

   always_ff @(posedge clock) begin
      p1_lp_ff  <= lp0;
      p1_rp_ff  <= rp0;
      p1_vol_ff <= vol0;
      s2l_ff    <= rd_ff[15:0];
      s2r_ff    <= rd_ff[31:16];
      p2_lp_ff  <= p1_lp_ff;
      p2_rp_ff  <= p1_rp_ff;
      p2_vol_ff <= p1_vol_ff;
      m3l_ff    <= 33'((s2l_ff * $signed({1'b0, p2_lp_ff})) >>> FRAC_BITS);
      m3r_ff    <= 33'((s2r_ff * $signed({1'b0, p2_rp_ff})) >>> FRAC_BITS);
      p3_vol_ff <= p2_vol_ff;
      m4l_ff    <= 37'((49'(m3l_ff) * $signed({1'b0, p3_vol_ff})) >>> FRAC_BITS);
      m4r_ff    <= 37'((49'(m3r_ff) * $signed({1'b0, p3_vol_ff})) >>> FRAC_BITS);
   end

   // accumulators saturate at the end only; width bounds the sum
   function automatic logic signed [15:0] sat16(input logic signed [ACW-1:0] v);
      if (v > 32'sd32767) begin
         return 16'sh7fff;
      end else if (v < -32'sd32768) begin
         return -16'sh8000;
      end
      return v[15:0];
   endfunction

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_ff      <= req_word;
         accl_ff     <= '0;
         accr_ff     <= '0;
         found_ff    <= SW'(VOICES);
         found_ok_ff <= 1'b0;
      end else begin
         if (p4_ff) begin
            accl_ff <= accl_ff + ACW'(m4l_ff);
            accr_ff <= accr_ff + ACW'(m4r_ff);
         end
         // lowest free voice: first inactive seen in scan order
         if (cmd.scan_step && !found_ok_ff && !act_ff[vi]) begin
            found_ff    <= SW'(idx_ff);
            found_ok_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.scan_clr) begin
         idx_ff <= '0;
      end else if (cmd.scan_step) begin
         idx_ff <= idx_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         rsp_ff.frame_valid   <= (req_ff.command == CMD_TICK);
         rsp_ff.mix_left      <= (req_ff.command == CMD_TICK) ? sat16(accl_ff) : '0;
         rsp_ff.mix_right     <= (req_ff.command == CMD_TICK) ? sat16(accr_ff) : '0;
         rsp_ff.started_voice <= (req_ff.command == CMD_START) ? found_ff : '0;
      end
   end

   assign sts.scan_last = (idx_ff == (VW+1)'(VOICES - 1));
   assign sts.pipe_busy = s0_ff | p1_ff | p2_ff | p3_ff | p4_ff;
   assign rsp_word      = rsp_ff;

   `MVSM_ASSERT_IMP(a_scan_in_range, cmd.scan_step, 32'(idx_ff) < VOICES, "scan index out of range")
   `MVSM_ASSERT_IMP(a_no_apply_midpipe, cmd.apply, !sts.pipe_busy, "apply while mixing")
   `MVSM_ASSERT_NEXT(a_found_valid, cmd.scan_step && !act_ff[vi] && !found_ok_ff, found_ok_ff, "free voice lost")
endmodule

[rtl/multi_voice_sample_mixer.sv]
// Multi-voice sample mixer. Each request word is one command; every command gives exactly one
// response word. A tick or a start walks all voices one per cycle, reading each voice's
// registers through a register stage ahead of a single shared mixing pipeline (two multipliers
// in series, registered). A stalled response word holds back the next one. The sample memory
// has one write and one registered read port and needs no clearing after reset.
// ----------------------------------------------------------------------------
// multi_voice_sample_mixer
// Top level: request/response handshakes, controller and datapath.
// ----------------------------------------------------------------------------
module multi_voice_sample_mixer #(
   parameter int SAMPLE_DEPTH = mvsm_pkg::SAMPLE_DEPTH_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  mvsm_pkg::req_word_type req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output mvsm_pkg::rsp_word_type rsp_data
);
   import mvsm_pkg::*;

   ctl_cmd_type cmd;
   ctl_sts_type sts;
   logic        rsp_valid_ff;

   mvsm_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_command (req_data.command),
      .rsp_busy    (rsp_valid_ff && rsp_stall),
      .cmd         (cmd),
      .sts         (sts)
   );

   mvsm_datapath #(
      .SAMPLE_DEPTH (SAMPLE_DEPTH)
   ) u_dp (
      .clock    (clock),
      .reset    (reset),
      .req_word (req_data),
      .cmd      (cmd),
      .sts      (sts),
      .rsp_word (rsp_data)
   );

   // output word register valid
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.finish) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_valid = rsp_valid_ff;
endmodule
